FILE: rtl/tone_sequencer_with_sweep_effect_macros.svh
// Assertion helper macros
`ifndef TONE_SEQUENCER_WITH_SWEEP_EFFECT_MACROS_SVH
`define TONE_SEQUENCER_WITH_SWEEP_EFFECT_MACROS_SVH
// implication checked every cycle outside reset
`define TSS_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("label failed");
// next-cycle implication
`define TSS_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("label failed");
`endif

FILE: rtl/tss_pkg.sv
//------------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the tone sequencer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package tss_pkg;
  localparam int PHRASE_COUNT     = 16;
  localparam int NOTES_PER_PHRASE = 64;
  localparam int ORDER_DEPTH      = 64;
  localparam int NOTE_DEPTH       = PHRASE_COUNT * NOTES_PER_PHRASE;
  localparam int NA_W  = $clog2(NOTE_DEPTH);
  localparam int PH_W  = 4;
  localparam int NP_W  = 7;
  localparam int OP_W  = 7;
  localparam int OA_W  = $clog2(ORDER_DEPTH);
  localparam int FREQ_W = 14;
  localparam int DIV_W  = 8;
  localparam int ENT_W  = FREQ_W + DIV_W;
  localparam int MS_W   = 18;

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_TRIG  = 3'd1;
  localparam logic [2:0] ACT_START = 3'd2;
  localparam logic [2:0] ACT_WNOTE = 3'd3;
  localparam logic [2:0] ACT_WORD  = 3'd4;

  localparam logic CFG_TEMPO = 1'b0;
  localparam logic CFG_OLEN  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;    // capture input beat
    logic do_simple;   // non-tick actions, effect, idle tick
    logic rd_order;    // issue order read at order addr
    logic use_ord0;    // order addr 0 (phrase load)
    logic ld_phrase;   // latch order data as phrase, reset note pos
    logic init_pos;    // order_position = 0
    logic rd_note;     // issue note read
    logic ld_entry;    // latch note data
    logic adv_order;   // order_position++
    logic end_track;   // end track, emit silence
    logic div_start;   // start length calculation
    logic finish;      // commit note, emit results
    logic play_only;   // emit play without reload
  } tss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic effect;
    logic active;
    logic zero_ms;
    logic loaded;
    logic entry_end;
    logic order_done;
    logic div_busy;
    logic out_busy;
  } tss_sts_t;
endpackage

FILE: rtl/tss_ram.sv
//------------------------------------------------------------------------------
// tss_ram
// Generic simple dual-port RAM (separate write and read ports) with registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/tss_div.sv
//------------------------------------------------------------------------------
// tss_div
// Restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [17:0] dividend,
  input  logic [17:0] divisor,
  output logic        busy,
  output logic [17:0] quot
);
  logic [4:0]  cnt_r;
  logic [17:0] rem_r, q_r, d_r;
  logic        busy_r;
  logic [18:0] trial;
  assign trial = {rem_r, q_r[17]} - {1'b0, d_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd18;
      rem_r  <= '0;
      q_r    <= dividend;
      d_r    <= divisor;
    end else if (busy_r) begin
      if (!trial[18]) begin
        rem_r <= trial[17:0];
        q_r   <= {q_r[16:0], 1'b1};
      end else begin
        rem_r <= {rem_r[16:0], q_r[17]};
        q_r   <= {q_r[16:0], 1'b0};
      end
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;
  assign quot = q_r;
endmodule

FILE: rtl/tss_datapath.sv
//------------------------------------------------------------------------------
// tss_datapath
// Stores, track state, length divider and two-entry result buffer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  tss_pkg::tss_cmd_t cmd,
  output tss_pkg::tss_sts_t sts,
  input  logic [39:0]     in_tdata,
  input  logic [2:0]      in_tuser,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [9:0]      cfg_data,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic [2:0]      out_tuser,
  output logic            out_tlast
);
  import tss_pkg::*;
  `include "tone_sequencer_with_sweep_effect_macros.svh"

  logic [9:0] tempo_r;
  logic [6:0] olen_r;
  logic [2:0] act_r;
  logic eff_r, trk_r, loaded_r;
  logic [4:0] estep_r;
  logic [OP_W-1:0] opos_r;
  logic [NP_W-1:0] npos_r;
  logic [PH_W-1:0] phr_r;
  logic [FREQ_W-1:0] mfreq_r;
  logic [MS_W-1:0] ms_r;
  logic [ENT_W-1:0] ent_r;
  logic [FREQ_W+1:0] ob_d_r [2];
  logic [1:0] ob_n_r;   // results queued
  logic ob_h_r;         // head index

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= 10'd160;
      olen_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TEMPO) begin
        if (cfg_data != 10'd0) tempo_r <= cfg_data;
      end else olen_r <= cfg_data[6:0];
    end
  end

  // fields: write_phrase[3:0], write_index[9:4], freq[23:10], div[31:24], ophrase[35:32]
  logic [3:0] wph;
  logic [5:0] widx;
  assign wph  = in_tdata[3:0];
  assign widx = in_tdata[9:4];

  logic nwe, owe;
  assign nwe = cmd.latch_in && in_tuser == ACT_WNOTE;
  assign owe = cmd.latch_in && in_tuser == ACT_WORD;

  logic [OA_W-1:0] oraddr;
  logic [PH_W-1:0] ord_q;
  assign oraddr = cmd.use_ord0 ? '0 : opos_r[OA_W-1:0];
  tss_ram #(.WIDTH(PH_W), .DEPTH(ORDER_DEPTH)) u_ord (
    .clk, .we(owe), .waddr(widx), .wdata(in_tdata[35:32]),
    .raddr(oraddr), .rdata(ord_q));

  logic [ENT_W-1:0] note_q;
  logic [NA_W-1:0] nraddr;
  assign nraddr = {phr_r, npos_r[5:0]};
  tss_ram #(.WIDTH(ENT_W), .DEPTH(NOTE_DEPTH)) u_note (
    .clk, .we(nwe), .waddr({wph, widx}), .wdata(in_tdata[31:10]),
    .raddr(nraddr), .rdata(note_q));

  // note beyond phrase end reads as end mark
  logic npos_oob;
  logic npos_oob_r;
  assign npos_oob = npos_r[6];
  always_ff @(posedge clk) if (cmd.rd_note) npos_oob_r <= npos_oob;

  // divider chain: 60000/tempo then *4/div
  logic dv_start, dv_busy;
  logic [17:0] dv_a, dv_b, dv_q;
  logic dv_phase_r, dv_run_r;
  tss_div u_div (.clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .busy(dv_busy), .quot(dv_q));
  assign dv_start = cmd.div_start || (dv_run_r && !dv_busy && !dv_phase_r);
  assign dv_a = cmd.div_start ? 18'd60000 : {dv_q[15:0], 2'b00};
  assign dv_b = cmd.div_start ? {8'd0, tempo_r} : {10'd0, ent_r[21:14]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_run_r <= 1'b0; dv_phase_r <= 1'b0;
    end else if (cmd.div_start) begin
      dv_run_r <= 1'b1; dv_phase_r <= 1'b0;
    end else if (dv_run_r && !dv_busy) begin
      if (!dv_phase_r) dv_phase_r <= 1'b1;
      else dv_run_r <= 1'b0;
    end
  end

  logic [FREQ_W-1:0] efreq;
  logic [10:0] drop;
  assign drop  = estep_r * 6'd60;
  assign efreq = 14'(11'd1800 - drop);

  function automatic logic [FREQ_W+1:0] pk(logic on, logic [FREQ_W-1:0] f, logic g);
    return {g, on, on ? f : '0};
  endfunction

  logic [FREQ_W+1:0] r0, r1;
  logic [1:0] rn;
  logic eff_n, trk_n;
  logic mon;
  logic [FREQ_W-1:0] newf;
  logic [MS_W-1:0] newms;
  always_comb begin
    newf  = ent_r[FREQ_W-1:0];
    newms = (ent_r[21:14] == 8'd0) ? '0 : dv_q;
    mon   = 1'b0;
    r0 = '0; r1 = '0; rn = 2'd0;
    eff_n = eff_r; trk_n = trk_r;
    if (cmd.do_simple) begin
      if (act_r == ACT_TICK) begin
        rn = 2'd1;
        if (eff_r) begin
          if (drop >= 11'd1600) begin eff_n = 1'b0; r0 = pk(1'b0, '0, 1'b0); end
          else r0 = pk(1'b1, efreq, 1'b0);
        end
      end
    end else if (cmd.end_track) begin
      rn = 2'd1; trk_n = 1'b0;
    end else if (cmd.finish) begin
      mon = newf != 0 && newf <= 14'd10000;
      if (newf != 0) begin
        rn = 2'd2; r0 = pk(1'b0, '0, 1'b1); r1 = pk(mon, newf, 1'b0);
      end else begin
        rn = 2'd1; r0 = pk(mon, newf, 1'b0);
      end
    end else if (cmd.play_only) begin
      rn = 2'd1;
      r0 = pk(mfreq_r != 0 && mfreq_r <= 14'd10000, mfreq_r, 1'b0);
    end
  end

  logic [MS_W-1:0] ms_base;
  assign ms_base = cmd.finish ? newms : ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r <= 1'b0; estep_r <= '0; trk_r <= 1'b0; loaded_r <= 1'b0;
      opos_r <= '0; npos_r <= '0; phr_r <= '0; mfreq_r <= '0; ms_r <= '0;
      ob_n_r <= '0; ob_h_r <= 1'b0; act_r <= ACT_TICK;
    end else begin
      if (cmd.latch_in) begin
        act_r <= in_tuser;
        if (in_tuser == ACT_START) begin trk_r <= 1'b1; ms_r <= '0; end
      end
      if (cmd.do_simple && act_r == ACT_TICK && eff_r) begin
        if (drop >= 11'd1600) estep_r <= '0;
        else estep_r <= estep_r + 5'd1;
      end
      eff_r <= cmd.latch_in ? (eff_r | (in_tuser == ACT_TRIG)) : eff_n;
      if (!cmd.latch_in) trk_r <= trk_n;
      if (cmd.init_pos) begin opos_r <= '0; loaded_r <= 1'b1; end
      if (cmd.ld_phrase) begin phr_r <= ord_q; npos_r <= '0; end
      if (cmd.ld_entry) ent_r <= npos_oob_r ? '0 : note_q;
      if (cmd.adv_order) opos_r <= opos_r + 7'd1;
      if (cmd.end_track) loaded_r <= 1'b0;
      if (cmd.finish) begin
        mfreq_r <= newf;
        if (!npos_r[6]) npos_r <= npos_r + 7'd1;
      end
      if (cmd.finish || cmd.play_only)
        ms_r <= (ms_base >= 18'd10) ? ms_base - 18'd10 : '0;
      if (rn != 2'd0) begin
        ob_d_r[0] <= r0; ob_d_r[1] <= r1; ob_n_r <= rn; ob_h_r <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        ob_n_r <= ob_n_r - 2'd1; ob_h_r <= 1'b1;
      end
    end
  end

  logic [FREQ_W+1:0] head;
  assign head = ob_d_r[ob_h_r];
  assign out_tvalid = ob_n_r != 2'd0;
  assign out_tdata  = {head[FREQ_W+1], head[FREQ_W-1:0], head[FREQ_W]};
  assign out_tuser  = '0 | {1'b0, eff_r, trk_r};
  assign out_tlast  = ob_n_r == 2'd1;

  assign sts.is_tick    = act_r == ACT_TICK;
  assign sts.effect     = eff_r;
  assign sts.active     = trk_r;
  assign sts.zero_ms    = ms_r == '0;
  assign sts.loaded     = loaded_r;
  assign sts.entry_end  = ent_r[21:14] == 8'd0;
  assign sts.order_done = opos_r >= olen_r || opos_r >= 7'(ORDER_DEPTH);
  assign sts.div_busy   = dv_run_r || dv_busy;
  assign sts.out_busy   = ob_n_r != 2'd0;

  `TSS_ASSERT_IMP(a_last_single, out_tvalid && ob_h_r, out_tlast)
  `TSS_ASSERT_IMP(a_gap_silent, out_tvalid && out_tdata[15], !out_tdata[0])
  `TSS_ASSERT_NXT(a_div_run, cmd.div_start, sts.div_busy)
endmodule

FILE: rtl/tss_ctrl.sv
//------------------------------------------------------------------------------
// tss_ctrl
// Sequencer for input beats, note reload and result hand-off.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tss_pkg::tss_sts_t sts,
  output tss_pkg::tss_cmd_t cmd
);
  import tss_pkg::*;
  `include "tone_sequencer_with_sweep_effect_macros.svh"

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DISP  = 13'b0000000000010,
    S_LD0   = 13'b0000000000100,
    S_LD0W  = 13'b0000000001000,
    S_NRD   = 13'b0000000010000,
    S_NWT   = 13'b0000000100000,
    S_CHK   = 13'b0000001000000,
    S_ORD   = 13'b0000010000000,
    S_ORDW  = 13'b0000100000000,
    S_DIV   = 13'b0001000000000,
    S_DWT   = 13'b0010000000000,
    S_WAIT  = 13'b0100000000000,
    S_RLD   = 13'b1000000000000
  } st_t;

  st_t st_r, st_nxt;

  always_comb begin
    cmd = '0;
    st_nxt = st_r;
    in_tready = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_tready = !sts.out_busy;
        if (in_tvalid && !sts.out_busy) begin
          cmd.latch_in = 1'b1; st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.is_tick || sts.effect || !sts.active) begin
          cmd.do_simple = 1'b1; st_nxt = S_WAIT;
        end else if (!sts.zero_ms) begin
          cmd.play_only = 1'b1; st_nxt = S_WAIT;
        end else if (!sts.loaded) begin
          cmd.init_pos = 1'b1; cmd.rd_order = 1'b1; cmd.use_ord0 = 1'b1;
          st_nxt = S_LD0;
        end else begin
          st_nxt = S_NRD;
        end
      end
      S_LD0:  begin cmd.use_ord0 = 1'b1; st_nxt = S_LD0W; end
      S_LD0W: begin cmd.ld_phrase = 1'b1; st_nxt = S_NRD; end
      S_NRD:  begin cmd.rd_note = 1'b1; st_nxt = S_NWT; end
      S_NWT:  begin cmd.ld_entry = 1'b1; st_nxt = S_CHK; end
      S_CHK: begin
        if (sts.entry_end) begin cmd.adv_order = 1'b1; st_nxt = S_ORD; end
        else begin cmd.div_start = 1'b1; st_nxt = S_DIV; end
      end
      S_ORD: begin
        if (sts.order_done) begin cmd.end_track = 1'b1; st_nxt = S_WAIT; end
        else st_nxt = S_ORDW;
      end
      S_ORDW: begin cmd.ld_phrase = 1'b1; cmd.rd_order = 1'b1; st_nxt = S_DWT; end
      S_DWT: begin
        cmd.rd_note = 1'b1; st_nxt = S_RLD;
      end
      // first note of the new phrase is taken as is, even an end mark
      S_RLD: begin
        cmd.ld_entry = 1'b1; cmd.div_start = 1'b1; st_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_busy) st_nxt = S_DIV;
        else begin
          cmd.finish = 1'b1; st_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.out_busy) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  `TSS_ASSERT_IMP(a_rdy_idle, in_tready, st_r == S_IDLE)
  `TSS_ASSERT_IMP(a_fin_nobusy, cmd.finish, !sts.div_busy)
  `TSS_ASSERT_NXT(a_latch_disp, in_tvalid && in_tready, st_r == S_DISP)
endmodule

FILE: rtl/tone_sequencer_with_sweep_effect.sv
// Sequencing: effect, idle and countdown ticks give their result beat from the
// dispatch state; a note reload runs two divider passes before the first result
// beat, and may first load the first phrase or change to the next phrase.
// Flow: one input beat at a time; a beat without results frees the input once
// the sequencer is back in idle, otherwise after the last result beat is taken.
// Reset: synchronous active-low rst_n clears control state; stores undefined.
//------------------------------------------------------------------------------
// tone_sequencer_with_sweep_effect
// Tone track player with priority falling sweep effect.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tone_sequencer_with_sweep_effect (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // write_phrase[3:0] write_index[9:4] note_frequency[23:10]
  // note_division[31:24] order_phrase[35:32]
  input  logic [39:0] in_tdata,
  input  logic [2:0]  in_tuser,   // action
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tone_on[0] tone_frequency[14:1] is_gap[15]
  output logic [15:0] out_tdata,
  output logic [2:0]  out_tuser,  // track_playing[0] effect_playing[1]
  output logic        out_tlast
);
  import tss_pkg::*;
  tss_cmd_t cmd;
  tss_sts_t sts;
  tss_ctrl u_ctrl (.clk, .rst_n, .in_tvalid, .in_tready, .sts, .cmd);
  tss_datapath u_dp (.clk, .rst_n, .cmd, .sts, .in_tdata, .in_tuser,
    .cfg_we, .cfg_index, .cfg_data, .out_tvalid, .out_tready, .out_tdata,
    .out_tuser, .out_tlast);
endmodule
